// ===== sv/ptd_pkg.sv =====
package ptd_pkg;

    // input and result words
    localparam int COORD_W   = 16;
    localparam int NUM_COORD = 8;
    localparam int IN_W      = COORD_W * NUM_COORD;
    localparam int DIST_W    = 17;
    localparam int OUT_FLD_W = DIST_W + 2;
    localparam int OUT_W     = ((OUT_FLD_W + 7) / 8) * 8;

    // internal arithmetic widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int WIDE_W = PROD_W + 4;

    // edge parameter fraction and divider
    localparam int PFRAC      = 16;
    localparam int FRAC_W     = PFRAC + 1;
    localparam int DIV_STAGES = FRAC_W;
    localparam int DEN_W      = WIDE_W - 1;
    localparam int N_W        = WIDE_W + PFRAC;

    // difference vector and square root
    localparam int VEC_SH    = 8;
    localparam int VP_W      = DIFF_W + FRAC_W + 1;
    localparam int V_W       = WIDE_W - VEC_SH;
    localparam int MAG_W     = 27;
    localparam int LO_W      = 13;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int X_W       = 2 * MAG_W + 4;
    localparam int ROOT_W    = X_W / 2;
    localparam int DF_W      = ROOT_W - VEC_SH;
    localparam int DIST_MAX  = (1 << DIST_W) - 1;

    // overall latency in register stages
    localparam int LAT = 6 + DIV_STAGES + 6 + ROOT_W + 1;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [VP_W-1:0]   t_vp;

    // how the edge parameter that is not divided is formed
    typedef enum logic [0:0] {
        OTH_ZERO      = 1'b0,
        OTH_ONE_MINUS = 1'b1
    } t_oth;

    typedef struct packed {
        t_diff e0x;
        t_diff e0y;
        t_diff e1x;
        t_diff e1y;
        t_diff qx;
        t_diff qy;
    } t_geo;

    typedef struct packed {
        t_geo  geo;
        logic  frac_s;
        t_oth  oth;
        logic  in_tri;
        logic  degen;
        logic  zero;
        logic  onef;
    } t_side;

endpackage

// ===== sv/point_triangle_distance_unit.sv =====
// channel   dir  fields (lowest bit up)
// s_axis    in   point_x, point_y, vertex_a_x/y, vertex_b_x/y, vertex_c_x/y
// m_axis    out  distance, inside_res, degenerate, zero pad
//
// one word accepted per cycle unless a waiting output word holds the pipeline, one result per word
// most of the pipeline depth lies in the 17-stage fraction divider and the 29-stage square root
// reset clears the stage valid bits only
// when the output word waits, the whole pipeline holds and nothing is lost
module point_triangle_distance_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [ptd_pkg::IN_W-1:0]   i_s_tdata,  // point_x, point_y, vertex_a_x, vertex_a_y,
                                                    // vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [ptd_pkg::OUT_W-1:0]  o_m_tdata   // distance, inside_res, degenerate, pad
);
    import ptd_pkg::*;

    logic           w_adv;
    logic [LAT-1:0] r_vld;

    // pipeline advance and valid shift
    assign w_adv      = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // stage 1: edge and offset vectors
    function automatic t_diff f_sub(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        f_sub = $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
    endfunction

    t_geo r_s1_geo;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_geo.e0x <= f_sub(i_s_tdata[2*COORD_W +: COORD_W], i_s_tdata[4*COORD_W +: COORD_W]);
            r_s1_geo.e0y <= f_sub(i_s_tdata[3*COORD_W +: COORD_W], i_s_tdata[5*COORD_W +: COORD_W]);
            r_s1_geo.e1x <= f_sub(i_s_tdata[6*COORD_W +: COORD_W], i_s_tdata[4*COORD_W +: COORD_W]);
            r_s1_geo.e1y <= f_sub(i_s_tdata[7*COORD_W +: COORD_W], i_s_tdata[5*COORD_W +: COORD_W]);
            r_s1_geo.qx  <= f_sub(i_s_tdata[0 +: COORD_W], i_s_tdata[4*COORD_W +: COORD_W]);
            r_s1_geo.qy  <= f_sub(i_s_tdata[COORD_W +: COORD_W], i_s_tdata[5*COORD_W +: COORD_W]);
        end
    end

    // stage 2: cross and dot products of the edge and offset vectors
    t_diff w1_e0x, w1_e0y, w1_e1x, w1_e1y, w1_qx, w1_qy;
    assign w1_e0x = r_s1_geo.e0x;
    assign w1_e0y = r_s1_geo.e0y;
    assign w1_e1x = r_s1_geo.e1x;
    assign w1_e1y = r_s1_geo.e1y;
    assign w1_qx  = r_s1_geo.qx;
    assign w1_qy  = r_s1_geo.qy;

    t_geo  r_s2_geo;
    t_prod r_p_det0, r_p_det1, r_p_sn0, r_p_sn1, r_p_tn0, r_p_tn1;
    t_prod r_p_a0, r_p_a1, r_p_b0, r_p_b1, r_p_c0, r_p_c1;
    t_prod r_p_d0, r_p_d1, r_p_e0, r_p_e1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_geo <= r_s1_geo;
            r_p_det0 <= w1_e0y * w1_e1x;
            r_p_det1 <= w1_e0x * w1_e1y;
            r_p_sn0  <= w1_qy * w1_e1x;
            r_p_sn1  <= w1_qx * w1_e1y;
            r_p_tn0  <= w1_qx * w1_e0y;
            r_p_tn1  <= w1_qy * w1_e0x;
            r_p_a0   <= w1_e0x * w1_e0x;
            r_p_a1   <= w1_e0y * w1_e0y;
            r_p_b0   <= w1_e0x * w1_e1x;
            r_p_b1   <= w1_e0y * w1_e1y;
            r_p_c0   <= w1_e1x * w1_e1x;
            r_p_c1   <= w1_e1y * w1_e1y;
            r_p_d0   <= w1_e0x * w1_qx;
            r_p_d1   <= w1_e0y * w1_qy;
            r_p_e0   <= w1_e1x * w1_qx;
            r_p_e1   <= w1_e1y * w1_qy;
        end
    end

    // stage 3: determinant, numerators, quadratic-form terms
    t_geo  r_s3_geo;
    t_wide r_s3_det, r_s3_sn, r_s3_tn, r_s3_a, r_s3_b, r_s3_c, r_s3_d, r_s3_e;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_geo <= r_s2_geo;
            r_s3_det <= WIDE_W'(r_p_det0) - WIDE_W'(r_p_det1);
            r_s3_sn  <= WIDE_W'(r_p_sn0) - WIDE_W'(r_p_sn1);
            r_s3_tn  <= WIDE_W'(r_p_tn0) - WIDE_W'(r_p_tn1);
            r_s3_a   <= WIDE_W'(r_p_a0) + WIDE_W'(r_p_a1);
            r_s3_b   <= WIDE_W'(r_p_b0) + WIDE_W'(r_p_b1);
            r_s3_c   <= WIDE_W'(r_p_c0) + WIDE_W'(r_p_c1);
            r_s3_d   <= -(WIDE_W'(r_p_d0) + WIDE_W'(r_p_d1));
            r_s3_e   <= -(WIDE_W'(r_p_e0) + WIDE_W'(r_p_e1));
        end
    end

    // stage 4: sign normalize and region terms
    t_geo  r_s4_geo;
    logic  r_s4_degen, r_s4_gt_c, r_s4_t1c_le0, r_s4_gt_a, r_s4_t1a_le0;
    t_wide r_s4_sn, r_s4_tn, r_s4_dm, r_s4_span, r_s4_num_c, r_s4_num_a;
    t_wide r_s4_negd, r_s4_nege, r_s4_a, r_s4_c;
    t_wide w3_t0c, w3_t1c, w3_t0a, w3_t1a;
    logic  w3_neg;
    assign w3_t0c = r_s3_b + r_s3_d;
    assign w3_t1c = r_s3_c + r_s3_e;
    assign w3_t0a = r_s3_b + r_s3_e;
    assign w3_t1a = r_s3_a + r_s3_d;
    assign w3_neg = r_s3_det[WIDE_W-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_geo     <= r_s3_geo;
            r_s4_degen   <= (r_s3_det == '0);
            r_s4_sn      <= w3_neg ? -r_s3_sn : r_s3_sn;
            r_s4_tn      <= w3_neg ? -r_s3_tn : r_s3_tn;
            r_s4_dm      <= w3_neg ? -r_s3_det : r_s3_det;
            r_s4_span    <= r_s3_a - (r_s3_b <<< 1) + r_s3_c;
            r_s4_gt_c    <= (w3_t1c > w3_t0c);
            r_s4_t1c_le0 <= (w3_t1c <= 0);
            r_s4_gt_a    <= (w3_t1a > w3_t0a);
            r_s4_t1a_le0 <= (w3_t1a <= 0);
            r_s4_num_c   <= w3_t1c - w3_t0c;
            r_s4_num_a   <= w3_t1a - w3_t0a;
            r_s4_negd    <= -r_s3_d;
            r_s4_nege    <= -r_s3_e;
            r_s4_a       <= r_s3_a;
            r_s4_c       <= r_s3_c;
        end
    end

    // stage 5: inside test and region select of the clamp operands
    t_wide w4_sum, w4_num, w4_den;
    logic  w4_inside, w4_frac_s;
    t_oth  w4_oth;
    assign w4_sum = r_s4_sn + r_s4_tn;

    always_comb begin
        w4_inside = !r_s4_degen && (r_s4_sn >= 0) && (r_s4_tn >= 0) && (w4_sum <= r_s4_dm);
        w4_num    = r_s4_nege;
        w4_den    = r_s4_c;
        w4_frac_s = 1'b0;
        w4_oth    = OTH_ZERO;
        if (r_s4_tn > 0) begin
            if (r_s4_sn > 0 || (w4_sum > r_s4_dm && r_s4_gt_c)) begin
                // beyond edge AC
                w4_num    = r_s4_num_c;
                w4_den    = r_s4_span;
                w4_frac_s = 1'b1;
                w4_oth    = OTH_ONE_MINUS;
            end else if (w4_sum > r_s4_dm && r_s4_t1c_le0) begin
                // vertex C itself
                w4_num = t_wide'(1);
                w4_den = t_wide'(1);
            end
        end else begin
            if (r_s4_sn < 0) begin
                if (r_s4_negd > 0) begin
                    w4_num    = r_s4_negd;
                    w4_den    = r_s4_a;
                    w4_frac_s = 1'b1;
                end
            end else if (w4_sum < r_s4_dm) begin
                // beyond edge AB
                w4_num    = r_s4_negd;
                w4_den    = r_s4_a;
                w4_frac_s = 1'b1;
            end else if (r_s4_gt_a) begin
                w4_num = r_s4_num_a;
                w4_den = r_s4_span;
                w4_oth = OTH_ONE_MINUS;
            end else begin
                w4_frac_s = 1'b1;
                if (r_s4_t1a_le0) begin
                    w4_num = t_wide'(1);
                    w4_den = t_wide'(1);
                end else begin
                    w4_num = r_s4_negd;
                    w4_den = r_s4_a;
                end
            end
        end
    end

    t_geo  r_s5_geo;
    t_wide r_s5_num, r_s5_den;
    logic  r_s5_inside, r_s5_degen, r_s5_frac_s;
    t_oth  r_s5_oth;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_geo    <= r_s4_geo;
            r_s5_num    <= w4_num;
            r_s5_den    <= w4_den;
            r_s5_inside <= w4_inside;
            r_s5_degen  <= r_s4_degen;
            r_s5_frac_s <= w4_frac_s;
            r_s5_oth    <= w4_oth;
        end
    end

    // stage 6: clamp cases and scaled, rounded dividend
    logic [N_W-1:0] w5_n;
    assign w5_n = {r_s5_num[WIDE_W-1:0], {PFRAC{1'b0}}} + N_W'(r_s5_den[DEN_W-1:0] >> 1);

    t_side             r_s6_side;
    logic [DEN_W-1:0]  r_s6_rem;
    logic [FRAC_W-1:0] r_s6_low;
    logic [DEN_W-1:0]  r_s6_den;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_side.geo    <= r_s5_geo;
            r_s6_side.frac_s <= r_s5_frac_s;
            r_s6_side.oth    <= r_s5_oth;
            r_s6_side.in_tri <= r_s5_inside;
            r_s6_side.degen  <= r_s5_degen;
            r_s6_side.zero   <= (r_s5_den <= 0) || (r_s5_num <= 0);
            r_s6_side.onef   <= (r_s5_num >= r_s5_den);
            r_s6_rem         <= w5_n[N_W-1:FRAC_W];
            r_s6_low         <= w5_n[FRAC_W-1:0];
            r_s6_den         <= r_s5_den[DEN_W-1:0];
        end
    end

    // fraction divider with side data alongside
    logic [FRAC_W-1:0] w_quo;
    t_side             r_dside [DIV_STAGES];

    ptd_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem (r_s6_rem),
        .i_low (r_s6_low),
        .i_den (r_s6_den),
        .o_quo (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dside[0] <= r_s6_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // v0: edge parameters s and t
    localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << PFRAC;
    t_side             w_dl;
    logic [FRAC_W-1:0] w_frac, w_other;
    assign w_dl    = r_dside[DIV_STAGES-1];
    assign w_frac  = w_dl.zero ? '0 : (w_dl.onef ? ONE : w_quo);
    assign w_other = (w_dl.oth == OTH_ONE_MINUS) ? (ONE - w_frac) : '0;

    t_geo              r_v0_geo;
    logic [FRAC_W-1:0] r_v0_sp, r_v0_tp;
    logic [1:0]        r_v0_flg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v0_geo <= w_dl.geo;
            r_v0_sp  <= w_dl.frac_s ? w_frac : w_other;
            r_v0_tp  <= w_dl.frac_s ? w_other : w_frac;
            r_v0_flg <= {w_dl.degen, w_dl.in_tri};
        end
    end

    // v1: parameter times edge products
    t_diff w0_e0x, w0_e0y, w0_e1x, w0_e1y;
    assign w0_e0x = r_v0_geo.e0x;
    assign w0_e0y = r_v0_geo.e0y;
    assign w0_e1x = r_v0_geo.e1x;
    assign w0_e1y = r_v0_geo.e1y;

    t_vp        r_v1_px0, r_v1_px1, r_v1_py0, r_v1_py1;
    t_diff      r_v1_qx, r_v1_qy;
    logic [1:0] r_v1_flg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v1_px0 <= $signed({1'b0, r_v0_sp}) * w0_e0x;
            r_v1_px1 <= $signed({1'b0, r_v0_tp}) * w0_e1x;
            r_v1_py0 <= $signed({1'b0, r_v0_sp}) * w0_e0y;
            r_v1_py1 <= $signed({1'b0, r_v0_tp}) * w0_e1y;
            r_v1_qx  <= r_v0_geo.qx;
            r_v1_qy  <= r_v0_geo.qy;
            r_v1_flg <= r_v0_flg;
        end
    end

    // v2: difference vector, rounded half up
    localparam int VEC_HALF = 1 << (VEC_SH - 1);
    t_wide w1_vx, w1_vy;
    assign w1_vx = (WIDE_W'(r_v1_px0) + WIDE_W'(r_v1_px1) - (WIDE_W'(r_v1_qx) <<< PFRAC)
                    + t_wide'(VEC_HALF)) >>> VEC_SH;
    assign w1_vy = (WIDE_W'(r_v1_py0) + WIDE_W'(r_v1_py1) - (WIDE_W'(r_v1_qy) <<< PFRAC)
                    + t_wide'(VEC_HALF)) >>> VEC_SH;

    logic signed [V_W-1:0] r_v2_vx, r_v2_vy;
    logic [1:0]            r_v2_flg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v2_vx  <= w1_vx[V_W-1:0];
            r_v2_vy  <= w1_vy[V_W-1:0];
            r_v2_flg <= r_v1_flg;
        end
    end

    // v3: component magnitudes
    logic [V_W-1:0] w2_ax, w2_ay;
    assign w2_ax = r_v2_vx[V_W-1] ? V_W'(-r_v2_vx) : V_W'(r_v2_vx);
    assign w2_ay = r_v2_vy[V_W-1] ? V_W'(-r_v2_vy) : V_W'(r_v2_vy);

    logic [MAG_W-1:0] r_v3_mx, r_v3_my;
    logic [1:0]       r_v3_flg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v3_mx  <= w2_ax[MAG_W-1:0];
            r_v3_my  <= w2_ay[MAG_W-1:0];
            r_v3_flg <= r_v2_flg;
        end
    end

    // v4: split squares into narrow partial products
    logic [2*HI_W-1:0]      r_v4_hhx, r_v4_hhy;
    logic [HI_W+LO_W-1:0]   r_v4_hlx, r_v4_hly;
    logic [2*LO_W-1:0]      r_v4_llx, r_v4_lly;
    logic [1:0]             r_v4_flg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v4_hhx <= r_v3_mx[MAG_W-1:LO_W] * r_v3_mx[MAG_W-1:LO_W];
            r_v4_hlx <= r_v3_mx[MAG_W-1:LO_W] * r_v3_mx[LO_W-1:0];
            r_v4_llx <= r_v3_mx[LO_W-1:0] * r_v3_mx[LO_W-1:0];
            r_v4_hhy <= r_v3_my[MAG_W-1:LO_W] * r_v3_my[MAG_W-1:LO_W];
            r_v4_hly <= r_v3_my[MAG_W-1:LO_W] * r_v3_my[LO_W-1:0];
            r_v4_lly <= r_v3_my[LO_W-1:0] * r_v3_my[LO_W-1:0];
            r_v4_flg <= r_v3_flg;
        end
    end

    // v5: four times the squared length
    logic [X_W-1:0] w4_x;
    assign w4_x = ((X_W'(r_v4_hhx) + X_W'(r_v4_hhy)) << (2 * LO_W + 2))
                + ((X_W'(r_v4_hlx) + X_W'(r_v4_hly)) << (LO_W + 3))
                + ((X_W'(r_v4_llx) + X_W'(r_v4_lly)) << 2);

    logic [X_W-1:0] r_v5_x;
    logic [1:0]     r_v5_flg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v5_x   <= w4_x;
            r_v5_flg <= r_v4_flg;
        end
    end

    // square root with flags alongside
    logic [ROOT_W-1:0] w_root;
    logic [1:0]        r_qflg [ROOT_W];

    ptd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (r_v5_x),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qflg[0] <= r_v5_flg;
            for (int k = 1; k < ROOT_W; k++) begin
                r_qflg[k] <= r_qflg[k-1];
            end
        end
    end

    // final: round, saturate, force zero inside or degenerate
    localparam int RND_ADD = 1 << VEC_SH;
    logic [ROOT_W:0]   w_rnd;
    logic [DF_W-1:0]   w_dfull;
    logic [DIST_W-1:0] w_dist;
    logic [1:0]        w_fl;
    assign w_rnd   = (ROOT_W+1)'(w_root) + (ROOT_W+1)'(RND_ADD);
    assign w_dfull = w_rnd[ROOT_W:VEC_SH+1];
    assign w_fl    = r_qflg[ROOT_W-1];

    always_comb begin
        if (w_fl != 2'b00) begin
            w_dist = '0;
        end else if (w_dfull > DF_W'(DIST_MAX)) begin
            w_dist = DIST_W'(DIST_MAX);
        end else begin
            w_dist = w_dfull[DIST_W-1:0];
        end
    end

    logic [OUT_W-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= OUT_W'({w_fl[1], w_fl[0], w_dist});
        end
    end

    assign o_m_tdata = r_out;

endmodule

// ===== sv/ptd_div.sv =====
module ptd_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptd_pkg::DEN_W-1:0]   i_rem,
    input  logic [ptd_pkg::FRAC_W-1:0]  i_low,
    input  logic [ptd_pkg::DEN_W-1:0]   i_den,
    output logic [ptd_pkg::FRAC_W-1:0]  o_quo
);
    import ptd_pkg::*;

    logic [DEN_W-1:0]  r_rem [DIV_STAGES];
    logic [FRAC_W-1:0] r_low [DIV_STAGES];
    logic [DEN_W-1:0]  r_den [DIV_STAGES];
    logic [FRAC_W-1:0] r_quo [DIV_STAGES];
    logic [DEN_W-1:0]  n_rem [DIV_STAGES];
    logic              n_bit [DIV_STAGES];

    // one quotient bit per stage, restoring
    always_comb begin
        logic [DEN_W:0]    cand;
        logic [DEN_W-1:0]  rem_p;
        logic [FRAC_W-1:0] low_p;
        logic [DEN_W-1:0]  den_p;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                rem_p = i_rem;
                low_p = i_low;
                den_p = i_den;
            end else begin
                rem_p = r_rem[k-1];
                low_p = r_low[k-1];
                den_p = r_den[k-1];
            end
            cand = {rem_p, low_p[FRAC_W-1]};
            n_bit[k] = (cand >= {1'b0, den_p});
            if (n_bit[k]) begin
                n_rem[k] = DEN_W'(cand - {1'b0, den_p});
            end else begin
                n_rem[k] = cand[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                if (k == 0) begin
                    r_low[k] <= {i_low[FRAC_W-2:0], 1'b0};
                    r_den[k] <= i_den;
                    r_quo[k] <= {{(FRAC_W-1){1'b0}}, n_bit[k]};
                end else begin
                    r_low[k] <= {r_low[k-1][FRAC_W-2:0], 1'b0};
                    r_den[k] <= r_den[k-1];
                    r_quo[k] <= {r_quo[k-1][FRAC_W-2:0], n_bit[k]};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// ===== sv/ptd_sqrt.sv =====
module ptd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptd_pkg::X_W-1:0]     i_x,
    output logic [ptd_pkg::ROOT_W-1:0]  o_root
);
    import ptd_pkg::*;

    localparam int RM_W = ROOT_W + 2;

    logic [X_W-1:0]    r_x    [ROOT_W];
    logic [RM_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RM_W-1:0]   n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // one root bit per stage, two radicand bits consumed
    always_comb begin
        logic [RM_W+1:0]   cand;
        logic [RM_W+1:0]   sub;
        logic [RM_W-1:0]   rem_p;
        logic [ROOT_W-1:0] root_p;
        logic [X_W-1:0]    x_p;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem_p  = '0;
                root_p = '0;
                x_p    = i_x;
            end else begin
                rem_p  = r_rem[k-1];
                root_p = r_root[k-1];
                x_p    = r_x[k-1];
            end
            cand = {rem_p, x_p[X_W-1-2*k], x_p[X_W-2-2*k]};
            sub  = (RM_W+2)'({root_p, 2'b01});
            if (cand >= sub) begin
                n_rem[k]  = RM_W'(cand - sub);
                n_root[k] = {root_p[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cand[RM_W-1:0];
                n_root[k] = {root_p[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                if (k == 0) begin
                    r_x[k] <= i_x;
                end else begin
                    r_x[k] <= r_x[k-1];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== sv/ptd_chk.sv =====
module ptd_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [ptd_pkg::OUT_W-1:0]  o_m_tdata
);
    import ptd_pkg::*;

    // a stalled result word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    // the input side only stalls behind a waiting result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with output empty");

    // inside or degenerate reports zero distance, never both flags
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[DIST_W] || o_m_tdata[DIST_W+1])
        |-> (o_m_tdata[DIST_W-1:0] == '0) && !(o_m_tdata[DIST_W] && o_m_tdata[DIST_W+1]))
        else $error("flagged result with nonzero distance");

    // pad bits stay clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_W-1:OUT_FLD_W] == '0))
        else $error("pad bits set");

endmodule

bind point_triangle_distance_unit ptd_chk u_ptd_chk (.*);
